// ----- rtl/keyboard_scan_queue_controller_top_macros.svh -----
// Assertion macros shared by the keyboard scan queue controller RTL.
`ifndef KEYBOARD_SCAN_QUEUE_CONTROLLER_TOP_MACROS_SVH
`define KEYBOARD_SCAN_QUEUE_CONTROLLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define KSQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KSQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define KSQ_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define KSQ_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/ksq_pkg.sv -----
// Shared types, constants and helper functions for the keyboard scan queue controller.
package ksq_pkg;

   // defaults for the top-level parameters
   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int KEY_BANKS_DEF   = 3;

   // field widths
   localparam int KEY_W      = 32;
   localparam int BIT_W      = 5;
   localparam int BANK_SEL_W = 2;
   localparam int CODE_W     = 8;
   localparam int FILL_W     = 6;
   localparam int LEVEL_W    = 3;
   localparam int MODE_W     = 2;

   // stream widths
   localparam int REQ_DATA_W = 104;
   localparam int REQ_USER_W = MODE_W;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - FILL_W - LEVEL_W - CODE_W;

   // code and status bytes
   localparam logic [CODE_W-1:0] STATUS_READY = 8'h98;
   localparam logic [CODE_W-1:0] STATUS_IDLE  = 8'h10;
   localparam logic [CODE_W-1:0] DATA_NONE    = 8'h00;

   // interrupt levels
   localparam logic [LEVEL_W-1:0] LEVEL_KEY   = 3'd6;
   localparam logic [LEVEL_W-1:0] LEVEL_TIMER = 3'd5;
   localparam logic [LEVEL_W-1:0] LEVEL_NONE  = 3'd0;

   // bank selectors for the fixed input words
   localparam logic [BANK_SEL_W-1:0] BANK_ZERO = 2'd0;
   localparam logic [BANK_SEL_W-1:0] BANK_ONE  = 2'd1;
   localparam logic [BANK_SEL_W-1:0] BANK_TWO  = 2'd2;

   // request kinds, encoded as the mode field
   typedef enum logic [MODE_W-1:0] {
      KIND_POLL   = 2'd0,
      KIND_READ   = 2'd1,
      KIND_STATUS = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // classified command passed from the front to the back
   typedef struct packed {
      kind_type          kind;
      logic              timer_irq;
      logic [KEY_W-1:0]  bank_two;
      logic [KEY_W-1:0]  bank_one;
      logic [KEY_W-1:0]  bank_zero;
   } cmd_type;

   // result transaction layout, lowest field last
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [FILL_W-1:0]    queue_fill;
      logic [LEVEL_W-1:0]   irq_level;
      logic [CODE_W-1:0]    read_data;
   } rsp_type;

   // status of the back end, seen by the top level
   typedef struct packed {
      logic key_irq;
      logic queue_empty;
   } stat_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [BIT_W-1:0] first_set(input logic [KEY_W-1:0] word);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = KEY_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ----- rtl/keyboard_scan_queue_controller_top.sv -----
// Top level of the keyboard scan queue controller: front end, back end and checks.
// Keyboard scan queue controller. Each request transaction is a key-matrix poll,
// a data read that pops the oldest key code, or a status read; each one gives
// exactly one response transaction carrying the read byte, the CPU interrupt
// level (key 6 over timer 5) and the number of queued codes. A two-entry
// command queue takes requests while the back end works, and the response sits
// in an output register. Path per request in the back end: a status read or
// unused mode goes straight to the done state, a data read passes through the
// pop state (registered read of the code RAM) unless the queue is empty, and a
// poll scans the banks in order: the scan records one change per cycle with a
// find-first over the current bank and moves to the next bank when no change
// is left; a poll that fills the queue ends early. A held response keeps the
// back end in the done state, so the next request waits until it is taken.
`include "keyboard_scan_queue_controller_top_macros.svh"

module keyboard_scan_queue_controller_top #(
   parameter int QUEUE_DEPTH = ksq_pkg::QUEUE_DEPTH_DEF,
   parameter int KEY_BANKS   = ksq_pkg::KEY_BANKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // key_bank_zero [31:0], key_bank_one [63:32], key_bank_two [95:64],
   // timer_irq [96], zero fill [103:97]
   input  logic [ksq_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode [1:0]
   input  logic [ksq_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // read_data [7:0], irq_level [10:8], queue_fill [16:11], zero fill [23:17]
   output logic [ksq_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import ksq_pkg::*;

   logic     cmd_valid;
   logic     cmd_ready;
   cmd_type  cmd;
   stat_type stat;
   rsp_type  rsp_view;

   // request intake and command queue
   ksq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // execution and response register
   ksq_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .KEY_BANKS  (KEY_BANKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .stat      (stat)
   );

   assign rsp_view = rsp_tdata;

   // checks
   `KSQ_ASSERT_IMP(a_irq_needs_codes, clock, reset, stat.key_irq, !stat.queue_empty,
                   "key interrupt set with an empty code queue")
   `KSQ_ASSERT_NXT(a_cmd_held, clock, reset, cmd_valid && !cmd_ready, cmd_valid,
                   "queued command dropped before the back end took it")
   `KSQ_ASSERT_IMP(a_level_legal, clock, reset, rsp_tvalid,
                   rsp_view.irq_level == LEVEL_NONE || rsp_view.irq_level == LEVEL_TIMER ||
                   rsp_view.irq_level == LEVEL_KEY,
                   "response carries an interrupt level that no source drives")

endmodule

// ----- rtl/ksq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ksq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ksq_front.sv -----
// Front end: accepts request transactions, classifies them and queues commands.
module ksq_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ksq_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [ksq_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output ksq_pkg::cmd_type             cmd
);

   import ksq_pkg::*;

   localparam int CMD_DEPTH = 2;
   localparam int PTR_W     = $clog2(CMD_DEPTH);
   localparam int CNT_W     = $clog2(CMD_DEPTH + 1);

   cmd_type          entry_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   cmd_type          new_cmd;
   logic             push, pop;

   // classify the incoming transaction
   always_comb begin
      new_cmd           = '0;
      new_cmd.bank_zero = req_tdata[KEY_W-1:0];
      new_cmd.bank_one  = req_tdata[2*KEY_W-1:KEY_W];
      new_cmd.bank_two  = req_tdata[3*KEY_W-1:2*KEY_W];
      new_cmd.timer_irq = req_tdata[3*KEY_W];
      unique case (req_tuser[MODE_W-1:0])
         KIND_POLL:   new_cmd.kind = KIND_POLL;
         KIND_READ:   new_cmd.kind = KIND_READ;
         KIND_STATUS: new_cmd.kind = KIND_STATUS;
         default:     new_cmd.kind = KIND_NONE;
      endcase
   end

   // command queue control
   assign req_tready = (fill_ff != CNT_W'(CMD_DEPTH));
   assign cmd_valid  = (fill_ff != '0);
   assign cmd        = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid & req_tready;
   assign pop        = cmd_valid & cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- rtl/ksq_back.sv -----
// Back end: runs key scans, code queue pops and status reads; holds the result register.
module ksq_back #(
   parameter int QUEUE_DEPTH = ksq_pkg::QUEUE_DEPTH_DEF,
   parameter int KEY_BANKS   = ksq_pkg::KEY_BANKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  ksq_pkg::cmd_type               cmd,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ksq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output ksq_pkg::stat_type              stat
);

   import ksq_pkg::*;

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int BANK_W = (KEY_BANKS > 1) ? $clog2(KEY_BANKS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_POP  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cur_ff, cur_in;
   logic [BANK_W-1:0] bank_ff, bank_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              irq_ff, irq_in;
   logic [KEY_W-1:0]  saved_ff [KEY_BANKS];
   logic [KEY_W-1:0]  saved_in [KEY_BANKS];
   logic [CODE_W-1:0] data_ff, data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [BANK_SEL_W-1:0] bank_sel;
   logic [KEY_W-1:0]      now_word;
   logic [KEY_W-1:0]      diff;
   logic [BIT_W-1:0]      bit_idx;
   logic [CODE_W-1:0]     code;
   logic                  full;
   logic                  last_bank;
   logic                  push_code;
   logic                  rd_en;
   logic [CODE_W-1:0]     rd_data;
   logic                  rsp_load;

   // current bank word and its changes against the saved state
   assign bank_sel = BANK_SEL_W'(bank_ff);

   always_comb begin
      unique case (bank_sel)
         BANK_ZERO: now_word = cur_ff.bank_zero;
         BANK_ONE:  now_word = cur_ff.bank_one;
         BANK_TWO:  now_word = cur_ff.bank_two;
         default:   now_word = '0;  // fourth bank has no input and reads released
      endcase
   end

   assign diff      = now_word ^ saved_ff[bank_ff];
   assign bit_idx   = first_set(diff);
   assign code      = {now_word[bit_idx], bank_sel, bit_idx};
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign last_bank = (bank_ff == BANK_W'(KEY_BANKS - 1));
   assign push_code = (state_ff == ST_SCAN) && !full && (diff != '0);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign cmd_ready = (state_ff == ST_IDLE);
   assign rd_en     = cmd_ready && cmd_valid && (cmd.kind == KIND_READ) && (count_ff != '0);

   // code queue storage
   ksq_ram #(
      .WIDTH(CODE_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_code_ram (
      .clock  (clock),
      .wr_en  (push_code),
      .wr_addr(tail_ff),
      .wr_data(code),
      .rd_en  (rd_en),
      .rd_addr(head_ff),
      .rd_data(rd_data)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      bank_in  = bank_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      irq_in   = irq_ff;
      data_in  = data_ff;
      for (int b = 0; b < KEY_BANKS; b++) begin
         saved_in[b] = saved_ff[b];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cur_in  = cmd;
               data_in = DATA_NONE;
               unique case (cmd.kind)
                  KIND_POLL: begin
                     bank_in  = '0;
                     state_in = ST_SCAN;
                  end
                  KIND_READ: begin
                     if (count_ff != '0) begin
                        state_in = ST_POP;
                     end else begin
                        irq_in   = 1'b0;  // empty read drops the key interrupt
                        state_in = ST_DONE;
                     end
                  end
                  KIND_STATUS: begin
                     data_in  = (count_ff != '0) ? STATUS_READY : STATUS_IDLE;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (full) begin
               state_in = ST_DONE;
            end else if (diff != '0) begin
               // record one change per cycle
               saved_in[bank_ff][bit_idx] = now_word[bit_idx];
               irq_in   = 1'b1;
               count_in = count_ff + CNT_W'(1);
               tail_in  = (tail_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + ADDR_W'(1);
            end else if (last_bank) begin
               state_in = ST_DONE;
            end else begin
               bank_in = bank_ff + BANK_W'(1);
            end
         end

         ST_POP: begin
            data_in  = rd_data;
            count_in = count_ff - CNT_W'(1);
            head_in  = (head_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + ADDR_W'(1);
            if (count_ff == CNT_W'(1)) begin
               irq_in = 1'b0;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in      = 1'b1;
         rsp_in.pad        = '0;
         rsp_in.read_data  = data_ff;
         rsp_in.queue_fill = FILL_W'(count_ff);
         if (irq_ff) begin
            rsp_in.irq_level = LEVEL_KEY;
         end else if (cur_ff.timer_irq) begin
            rsp_in.irq_level = LEVEL_TIMER;
         end else begin
            rsp_in.irq_level = LEVEL_NONE;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         irq_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < KEY_BANKS; b++) begin
            saved_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         irq_ff       <= irq_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int b = 0; b < KEY_BANKS; b++) begin
            saved_ff[b] <= saved_in[b];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      data_ff <= data_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_ff;
   assign stat.key_irq     = irq_ff;
   assign stat.queue_empty = (count_ff == '0);

endmodule
